// ===== rtl/pfx_pkg.sv =====
// Shared types and constants for the postfix expression evaluator.
// Used by pfx_ctrl, pfx_dp, pfx_div and the top level; depends on nothing.
package pfx_pkg;

    localparam int DATA_W   = 32;
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ERR_NONE     = 3'd0;
    localparam logic [STATUS_W-1:0] ERR_FEW      = 3'd1;
    localparam logic [STATUS_W-1:0] ERR_DIV0     = 3'd2;
    localparam logic [STATUS_W-1:0] ERR_INVALID  = 3'd3;
    localparam logic [STATUS_W-1:0] ERR_OVERFLOW = 3'd4;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

    localparam logic [DATA_W-1:0] ERR_VALUE = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EFLUSH,
        ST_OP_READ,
        ST_OP_EXEC,
        ST_DIV,
        ST_WB,
        ST_END
    } pfx_state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic digit_step;
        logic flush;
        logic rd_issue;
        logic exec;
        logic writeback;
        logic out_load;
    } pfx_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_digit;
        logic is_op;
        logic is_div;
        logic last;
        logic err;
        logic count_lt2;
        logic b_zero;
        logic div_done;
    } pfx_stat_t;

endpackage

// ===== rtl/postfix_expression_evaluator_top.sv =====
// Top level of the postfix expression evaluator.
// Joins pfx_ctrl and pfx_dp; uses pfx_pkg.
//
// Input channel: one ASCII character per transfer on s_tdata, s_tlast set on
// the final character of an expression. Digits build a number; + - * / pop two
// operands and push the 32-bit wrapped result; other characters are skipped.
// Result channel: one transfer per expression, the value on m_tdata and the
// status on m_tuser (0 ok, 1 too few operands, 2 divide by zero, 3 invalid
// expression, 4 stack overflow); the value is -1 whenever status is not 0.
// Characters are taken one at a time: the next is accepted only once the
// current one is done. A digit or skipped character is captured and decoded;
// + - * also read the stack, execute and write back, and / waits for the
// iterative divider. The final character then loads the result register, a
// final digit being pushed first. The operand stack is a single-port-write,
// registered-read memory, so each operator has a read state and a write-back state.
// Reset (aresetn low, synchronous) empties the stack and drops any pending
// result. A stalled receiver holds the result; the next expression is taken
// meanwhile and only its final character waits for the output register.
module postfix_expression_evaluator_top #(
    parameter int STACK_DEPTH = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value
    output logic [2:0]  m_tuser    // [2:0] status
);
    import pfx_pkg::*;

    pfx_cmd_t  cmd;
    pfx_stat_t stat;

    pfx_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfx_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_char    (s_tdata),
        .in_last    (s_tlast),
        .cmd        (cmd),
        .stat       (stat),
        .out_value  (m_tdata),
        .out_status (m_tuser)
    );

    a_err_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ERR_NONE) |-> (m_tdata == ERR_VALUE))
        else $error("error result without all-ones value");

endmodule

// ===== rtl/pfx_div.sv =====
// Iterative unsigned divider, one quotient bit per cycle.
// Depends on pfx_pkg for the data width.
module pfx_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [pfx_pkg::DATA_W-1:0] dividend,
    input  logic [pfx_pkg::DATA_W-1:0] divisor,
    output logic                       done,
    output logic [pfx_pkg::DATA_W-1:0] quotient
);
    import pfx_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dsr_reg, dsr_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;

    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (!diff[DATA_W]) begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DATA_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/pfx_dp.sv =====
// Datapath: character register, number accumulator, operand stack memory with
// a cached top entry, ALU, divider and the result register. Uses pfx_pkg, pfx_div.
module pfx_dp #(
    parameter int STACK_DEPTH = 128
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [pfx_pkg::CHAR_W-1:0]   in_char,
    input  logic                         in_last,
    input  pfx_pkg::pfx_cmd_t            cmd,
    output pfx_pkg::pfx_stat_t           stat,
    output logic [pfx_pkg::DATA_W-1:0]   out_value,
    output logic [pfx_pkg::STATUS_W-1:0] out_status
);
    import pfx_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [DATA_W-1:0] mem [STACK_DEPTH];

    logic [CHAR_W-1:0]   char_reg;
    logic                last_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic [DATA_W-1:0]   acc_reg, acc_next;
    logic                in_num_reg, in_num_next;
    logic [STATUS_W-1:0] err_reg, err_next;
    logic [DATA_W-1:0]   tos_reg, tos_next;
    logic [DATA_W-1:0]   res_reg, res_next;
    logic [DATA_W-1:0]   rdata_reg;
    logic                neg_reg, neg_next;
    logic [DATA_W-1:0]   out_value_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [DATA_W-1:0]   out_value_next;
    logic [STATUS_W-1:0] out_status_next;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [CW-1:0]     cnt_m2;
    logic              no_err;
    logic              is_digit;
    logic [3:0]        digit;
    logic [2*DATA_W-1:0] prod;
    logic [DATA_W-1:0] op_a, op_b;
    logic [DATA_W-1:0] mag_a, mag_b;
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_q;

    assign no_err   = (err_reg == ERR_NONE);
    assign is_digit = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
    assign digit    = 4'(char_reg - CH_ZERO);
    assign cnt_m2   = count_reg - CW'(2);
    assign op_a     = rdata_reg;
    assign op_b     = tos_reg;
    assign prod     = op_a * op_b;
    assign mag_a    = op_a[DATA_W-1] ? (~op_a + DATA_W'(1)) : op_a;
    assign mag_b    = op_b[DATA_W-1] ? (~op_b + DATA_W'(1)) : op_b;

    always_comb begin
        count_next      = count_reg;
        acc_next        = acc_reg;
        in_num_next     = in_num_reg;
        err_next        = err_reg;
        tos_next        = tos_reg;
        res_next        = res_reg;
        neg_next        = neg_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[AW-1:0];
        mem_wdata       = acc_reg;
        div_start       = 1'b0;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;

        if (cmd.digit_step) begin
            acc_next    = (acc_reg << 3) + (acc_reg << 1) + DATA_W'(digit);
            in_num_next = 1'b1;
        end

        if (cmd.flush && in_num_reg) begin
            if (count_reg >= CW'(STACK_DEPTH)) begin
                if (no_err) err_next = ERR_OVERFLOW;
            end else begin
                mem_we     = 1'b1;
                tos_next   = acc_reg;
                count_next = count_reg + CW'(1);
            end
            in_num_next = 1'b0;
            acc_next    = '0;
        end

        if (cmd.rd_issue && stat.count_lt2 && no_err) begin
            err_next = ERR_FEW;
        end

        if (cmd.exec) begin
            case (char_reg)
                CH_PLUS:  res_next = op_a + op_b;
                CH_MINUS: res_next = op_a - op_b;
                CH_STAR:  res_next = prod[DATA_W-1:0];
                CH_SLASH: begin
                    if (op_b == '0) begin
                        if (no_err) err_next = ERR_DIV0;
                    end else begin
                        div_start = 1'b1;
                        neg_next  = op_a[DATA_W-1] ^ op_b[DATA_W-1];
                    end
                end
                default: res_next = res_reg;
            endcase
        end

        // Apply the quotient sign as the divider finishes
        if (div_done) begin
            res_next = neg_reg ? (~div_q + DATA_W'(1)) : div_q;
        end

        if (cmd.writeback) begin
            mem_we     = 1'b1;
            mem_waddr  = cnt_m2[AW-1:0];
            mem_wdata  = res_reg;
            tos_next   = res_reg;
            count_next = count_reg - CW'(1);
        end

        if (cmd.out_load) begin
            if (!no_err) begin
                out_status_next = err_reg;
            end else if (count_reg != CW'(1)) begin
                out_status_next = ERR_INVALID;
            end else begin
                out_status_next = ERR_NONE;
            end
            out_value_next = (out_status_next == ERR_NONE) ? tos_reg : ERR_VALUE;
            count_next  = '0;
            acc_next    = '0;
            in_num_next = 1'b0;
            err_next    = ERR_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            acc_reg    <= '0;
            in_num_reg <= 1'b0;
            err_reg    <= ERR_NONE;
        end else begin
            count_reg  <= count_next;
            acc_reg    <= acc_next;
            in_num_reg <= in_num_next;
            err_reg    <= err_next;
        end
        if (cmd.capture) begin
            char_reg <= in_char;
            last_reg <= in_last;
        end
        tos_reg        <= tos_next;
        res_reg        <= res_next;
        neg_reg        <= neg_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    // Operand stack: one write port, one registered read port at count - 2
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_issue) begin
            rdata_reg <= mem[cnt_m2[AW-1:0]];
        end
    end

    pfx_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mag_a),
        .divisor  (mag_b),
        .done     (div_done),
        .quotient (div_q)
    );

    assign stat.is_digit  = is_digit;
    assign stat.is_op     = (char_reg == CH_PLUS) || (char_reg == CH_MINUS) ||
                            (char_reg == CH_STAR) || (char_reg == CH_SLASH);
    assign stat.is_div    = (char_reg == CH_SLASH);
    assign stat.last      = last_reg;
    assign stat.err       = !no_err;
    assign stat.count_lt2 = (count_reg < CW'(2));
    assign stat.b_zero    = (tos_reg == '0);
    assign stat.div_done  = div_done;

    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != ERR_NONE && !cmd.out_load) |=> $stable(err_reg))
        else $error("latched error changed before result");

    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> (count_reg == '0 && err_reg == ERR_NONE && !in_num_reg))
        else $error("frame state not cleared after result");

endmodule

// ===== rtl/pfx_ctrl.sv =====
// Controller: sequences each character through decode, stack read, execute,
// divide and write back, and owns both handshakes. Uses pfx_pkg.
module pfx_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  pfx_pkg::pfx_stat_t stat,
    output pfx_pkg::pfx_cmd_t  cmd
);
    import pfx_pkg::*;

    pfx_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;
    pfx_state_t after_item;

    assign out_free   = !m_valid_reg || m_tready;
    assign after_item = stat.last ? ST_END : ST_IDLE;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                if (stat.err) begin
                    state_next = after_item;
                end else if (stat.is_digit) begin
                    state_next = stat.last ? ST_EFLUSH : ST_IDLE;
                end else if (stat.is_op) begin
                    state_next = ST_OP_READ;
                end else begin
                    state_next = after_item;
                end
            end
            ST_EFLUSH: state_next = ST_END;
            ST_OP_READ: begin
                if (stat.err || stat.count_lt2) state_next = after_item;
                else state_next = ST_OP_EXEC;
            end
            ST_OP_EXEC: begin
                if (!stat.is_div) state_next = ST_WB;
                else if (stat.b_zero) state_next = after_item;
                else state_next = ST_DIV;
            end
            ST_DIV: begin
                if (stat.div_done) state_next = ST_WB;
            end
            ST_WB: state_next = after_item;
            ST_END: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_DECODE: begin
                cmd.digit_step = !stat.err && stat.is_digit;
                cmd.flush      = !stat.err && !stat.is_digit;
            end
            ST_EFLUSH:  cmd.flush     = 1'b1;
            ST_OP_READ: cmd.rd_issue  = 1'b1;
            ST_OP_EXEC: cmd.exec      = 1'b1;
            ST_WB:      cmd.writeback = 1'b1;
            ST_END:     cmd.out_load  = out_free;
            default:    cmd           = '0;
        endcase
    end

    // Hold the result until the transfer completes
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) m_valid_next = 1'b1;
        else if (m_tready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule
